@@ rtl/iqpd_pkg.sv @@
package iqpd_pkg;

  typedef struct packed {
    logic              op;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [7:0]  base_x;
    logic signed [7:0]  base_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] out_x;
    logic signed [7:0] out_y;
    logic [1:0]        moved_axes;
  } out_beat_t;

  localparam int QW        = 16;
  localparam int PROD_W    = 33;
  localparam int SUM_W     = 36;
  localparam int DELTA_W   = 54;
  localparam int FRAC_BITS = 28;
  localparam int RES_W     = 29;
  localparam int REPORT_MAX = 127;
  localparam logic [15:0] ANG_SCALE_RST = 16'd1600;

  typedef struct packed {
    logic                      start;
    logic signed [QW-1:0]      a;
    logic signed [QW-1:0]      b;
  } mul_req_t;

endpackage

@@ rtl/iqpd_serial_mul.sv @@
module iqpd_serial_mul #(
  parameter int AW = 16,
  parameter int BW = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] prod
);
  localparam int CW = $clog2(BW + 1);

  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic        [BW-1:0]    mplier;
  logic        [CW-1:0]    cnt;
  logic                    busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CW'(BW);
        acc    <= '0;
        mcand  <= (AW+BW)'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/imu_quaternion_to_pointer_delta.sv @@
// Channel | Dir | Handshake        | Payload
// in      | in  | in_valid/in_stall | iqpd_pkg::in_beat_t
// out     | out | out_valid/out_stall| iqpd_pkg::out_beat_t
// cfg     | in  | cfg_we           | ang_scale, 16 bit
// Sample beat: eight quaternion products then two gain products, each started
// in turn on the single 20-by-36-bit bit-serial multiplier, and an accumulate
// step per axis after its gain product.
// Report beat: accept, drain, then the output register.
// Reset clears state and pending counts; one beat is worked at a time, and a
// finished result waits in the output register while stall is high.
module imu_quaternion_to_pointer_delta #(
  parameter int PENDING_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iqpd_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iqpd_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);
  localparam int QW = iqpd_pkg::QW;
  localparam int SW = iqpd_pkg::SUM_W;
  localparam int DW = iqpd_pkg::DELTA_W;
  localparam int FB = iqpd_pkg::FRAC_BITS;
  localparam int RW = iqpd_pkg::RES_W;
  localparam int PB = PENDING_BITS;
  localparam int EW = DW + 2;
  localparam int MA = 20;
  localparam int MB = SW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SCL  = 3'd3;
  localparam logic [2:0] S_SWT  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_DRN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [15:0] ang_scale;
  logic signed [QW-1:0] prev [4];
  logic signed [QW-1:0] cur  [4];
  logic first_sample;
  logic signed [RW-1:0] res [2];
  logic signed [PB-1:0] pend [2];
  logic signed [SW-1:0] rsum [2];
  logic signed [DW-1:0] delta [2];
  logic [2:0] k;
  logic ax;
  logic signed [7:0] bx, by;
  iqpd_pkg::out_beat_t obuf;

  logic m_start, m_done;
  logic signed [MA-1:0] m_a;
  logic [MB-1:0] m_b;
  logic signed [MA+MB-1:0] m_p;

  iqpd_serial_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_p)
  );

  // rx = -p1*e + p0*f - p2*h + p3*g ; rz = p0*h - p1*g + p2*f - p3*e
  logic signed [QW-1:0] ta, tb;
  logic tneg, tz;
  always_comb begin
    ta = prev[0]; tb = cur[0]; tneg = 1'b0; tz = 1'b0;
    case (k)
      3'd0: begin ta = prev[1]; tb = cur[0]; tneg = 1'b1; tz = 1'b1; end
      3'd1: begin ta = prev[0]; tb = cur[1]; tneg = 1'b0; tz = 1'b1; end
      3'd2: begin ta = prev[2]; tb = cur[3]; tneg = 1'b1; tz = 1'b1; end
      3'd3: begin ta = prev[3]; tb = cur[2]; tneg = 1'b0; tz = 1'b1; end
      3'd4: begin ta = prev[0]; tb = cur[3]; tneg = 1'b0; tz = 1'b0; end
      3'd5: begin ta = prev[1]; tb = cur[2]; tneg = 1'b1; tz = 1'b0; end
      3'd6: begin ta = prev[2]; tb = cur[1]; tneg = 1'b0; tz = 1'b0; end
      default: begin ta = prev[3]; tb = cur[0]; tneg = 1'b1; tz = 1'b0; end
    endcase
  end

  // unsigned multiplier b: the operand passes b as its two's complement bit
  // pattern over MB bits; m_fix corrects the MA+MB result when b is negative
  always_comb begin
    m_a = '0;
    m_b = '0;
    if (state == S_SCL || state == S_SWT) begin
      m_a = MA'($signed({1'b0, ang_scale}));
      m_b = MB'(rsum[ax]);
    end else begin
      m_a = MA'(ta);
      m_b = MB'(tb);
    end
  end

  // shift-add over all MB bits of a two's complement b gives a*(b + 2^MB)
  // when b is negative; correct by subtracting a*2^MB in that case.
  logic signed [MA+MB:0] m_fix;
  logic b_neg;
  logic signed [MA-1:0] m_a_q;
  assign m_fix = (MA+MB+1)'(m_p) - (b_neg ? ((MA+MB+1)'(m_a_q) <<< MB) : '0);

  logic signed [SW-1:0] prod_s;
  assign prod_s = SW'(m_fix);

  logic signed [EW-1:0] ssum, whole_e;
  logic signed [EW-1:0] wsh;
  logic signed [PB+1:0] pn;
  logic signed [PB-1:0] pmax, pmin;
  assign pmax = {1'b0, {(PB-1){1'b1}}};
  assign pmin = {1'b1, {(PB-1){1'b0}}};

  always_comb begin
    ssum = EW'(res[ax]) - (EW'(delta[ax]) <<< 1);
    wsh = ssum >>> FB;
    whole_e = (ssum[EW-1] && (ssum[FB-1:0] != '0)) ? wsh + EW'(1) : wsh;
    pn = (PB+2)'(pend[ax]) + (PB+2)'(whole_e);
    if (whole_e > EW'(pmax) - EW'(pmin)) pn = (PB+2)'(pmax);
    if (whole_e < EW'(pmin) - EW'(pmax)) pn = (PB+2)'(pmin);
  end

  // drain
  function automatic logic [PB+8:0] drain_f(input logic signed [PB-1:0] p,
                                           input logic signed [7:0] bin);
    logic signed [8:0] b, room;
    logic signed [PB:0] d;
    b = (bin < -8'sd127) ? -9'sd127 : 9'(bin);
    if (p > 0) begin
      room = 9'sd127 - b;
      d = ((PB+1)'(p) < (PB+1)'(room)) ? (PB+1)'(p) : (PB+1)'(room);
    end else begin
      room = -9'sd127 - b;
      d = ((PB+1)'(p) > (PB+1)'(room)) ? (PB+1)'(p) : (PB+1)'(room);
    end
    drain_f = {d[PB-1:0], 8'(b + 9'(d)), (d != '0)};
  endfunction

  logic [PB+8:0] dx, dy;
  assign dx = drain_f(pend[0], bx);
  assign dy = drain_f(pend[1], by);

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ang_scale <= iqpd_pkg::ANG_SCALE_RST;
      first_sample <= 1'b1;
      for (int i = 0; i < 4; i++) prev[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        res[i] <= '0;
        pend[i] <= '0;
      end
      m_start <= 1'b0;
      k <= '0;
      ax <= 1'b0;
    end else begin
      m_start <= 1'b0;
      if (cfg_we) ang_scale <= cfg_data;
      unique case (state)
        S_IDLE: if (in_valid) begin
          if (in_data.op) begin
            bx <= in_data.base_x;
            by <= in_data.base_y;
            state <= S_DRN;
          end else begin
            cur[0] <= in_data.quat_w; cur[1] <= in_data.quat_x;
            cur[2] <= in_data.quat_y; cur[3] <= in_data.quat_z;
            if (first_sample) begin
              prev[0] <= in_data.quat_w; prev[1] <= in_data.quat_x;
              prev[2] <= in_data.quat_y; prev[3] <= in_data.quat_z;
              first_sample <= 1'b0;
            end
            rsum[0] <= '0; rsum[1] <= '0;
            k <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          m_start <= 1'b1;
          m_a_q <= m_a;
          b_neg <= m_b[MB-1];
          state <= S_WAIT;
        end
        S_WAIT: if (m_done) begin
          if (tneg) rsum[tz] <= rsum[tz] - prod_s;
          else      rsum[tz] <= rsum[tz] + prod_s;
          k <= k + 3'd1;
          if (k == 3'd7) begin
            ax <= 1'b0;
            state <= S_SCL;
          end else state <= S_MUL;
        end
        S_SCL: begin
          m_start <= 1'b1;
          m_a_q <= m_a;
          b_neg <= m_b[MB-1];
          state <= S_SWT;
        end
        S_SWT: if (m_done) begin
          delta[ax] <= DW'(m_fix);
          state <= S_ACC;
        end
        S_ACC: begin
          res[ax] <= RW'(ssum - (whole_e <<< FB));
          pend[ax] <= PB'(pn > (PB+2)'(pmax) ? (PB+2)'(pmax) :
                          pn < (PB+2)'(pmin) ? (PB+2)'(pmin) : pn);
          if (ax) begin
            for (int i = 0; i < 4; i++) prev[i] <= cur[i];
            state <= S_IDLE;
          end else begin
            ax <= 1'b1;
            state <= S_SCL;
          end
        end
        S_DRN: begin
          pend[0] <= pend[0] - dx[PB+8:9];
          pend[1] <= pend[1] - dy[PB+8:9];
          obuf.out_x <= dx[8:1];
          obuf.out_y <= dy[8:1];
          obuf.moved_axes <= 2'(dx[0]) + 2'(dy[0]);
          state <= S_OUT;
        end
        default: if (!out_stall) state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/iqpd_checker.sv @@
module iqpd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input iqpd_pkg::out_beat_t out_data,
  input logic                out_valid,
  input logic                out_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.moved_axes != 2'd3 && out_data.out_x != 8'sh80
      && out_data.out_y != 8'sh80)
    else $error("result out of range");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");
endmodule

bind imu_quaternion_to_pointer_delta iqpd_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);

@@ test/pointer_delta_checker.sv @@
module pointer_delta_checker #(
  parameter int PENDING_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  iqpd_pkg::in_beat_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  iqpd_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   reports_waiting
);
  import iqpd_pkg::*;

  localparam longint PEND_HI = (longint'(1) << (PENDING_BITS - 1)) - 1;
  localparam longint PEND_LO = -PEND_HI - 1;
  localparam longint ONE_COUNT = longint'(1) << FRAC_BITS;

  logic [15:0] gain;
  longint last_q [4];
  bit no_prev;
  longint residue [2];
  longint pending [2];
  out_beat_t report_q [$];

  function automatic void add_angle(int axis, longint part);
    longint sum;
    longint whole;
    longint p;
    sum = residue[axis] + (-2) * part * longint'(gain);
    whole = sum / ONE_COUNT;
    residue[axis] = sum - whole * ONE_COUNT;
    p = pending[axis] + whole;
    if (p > PEND_HI) p = PEND_HI;
    if (p < PEND_LO) p = PEND_LO;
    pending[axis] = p;
  endfunction

  function automatic int drain_axis(int axis, longint base, output logic signed [7:0] res);
    longint pend;
    longint d;
    longint room;
    pend = pending[axis];
    if (base < -REPORT_MAX) base = -REPORT_MAX;
    if (pend > 0) begin
      room = REPORT_MAX - base;
      d = (pend < room) ? pend : room;
    end else begin
      room = -REPORT_MAX - base;
      d = (pend > room) ? pend : room;
    end
    pending[axis] = pend - d;
    res = 8'(base + d);
    return (d != 0) ? 1 : 0;
  endfunction

  function automatic void apply_beat(in_beat_t b);
    longint e, f, g, h, a, bb, c, d, rx, rz;
    out_beat_t r;
    int moved;
    if (b.op == 1'b0) begin
      e = b.quat_w; f = b.quat_x; g = b.quat_y; h = b.quat_z;
      if (no_prev) begin
        last_q[0] = e; last_q[1] = f; last_q[2] = g; last_q[3] = h;
        no_prev = 0;
      end
      a = last_q[0]; bb = -last_q[1]; c = -last_q[2]; d = -last_q[3];
      rx = bb * e + a * f + c * h - d * g;
      rz = a * h + bb * g - c * f + d * e;
      add_angle(0, rz);
      add_angle(1, rx);
      last_q[0] = e; last_q[1] = f; last_q[2] = g; last_q[3] = h;
    end else begin
      moved = drain_axis(0, longint'(b.base_x), r.out_x);
      moved += drain_axis(1, longint'(b.base_y), r.out_y);
      r.moved_axes = 2'(moved);
      report_q.push_back(r);
    end
  endfunction

  assign reports_waiting = report_q.size();

  always @(posedge clk) begin
    out_beat_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      gain <= ANG_SCALE_RST;
      no_prev = 1;
      for (int i = 0; i < 4; i++) last_q[i] = 0;
      for (int i = 0; i < 2; i++) begin
        residue[i] = 0;
        pending[i] = 0;
      end
      report_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) gain <= cfg_data;
      if (in_valid && !in_stall) apply_beat(in_data);
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("unexpected report beat x=%0d y=%0d", out_data.out_x, out_data.out_y);
          errs++;
        end else begin
          exp_r = report_q.pop_front();
          if (out_data.out_x !== exp_r.out_x) begin
            $error("out_x expected %0d got %0d", exp_r.out_x, out_data.out_x);
            errs++;
          end
          if (out_data.out_y !== exp_r.out_y) begin
            $error("out_y expected %0d got %0d", exp_r.out_y, out_data.out_y);
            errs++;
          end
          if (out_data.moved_axes !== exp_r.moved_axes) begin
            $error("moved_axes expected %0d got %0d", exp_r.moved_axes,
                   out_data.moved_axes);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ test/testbench.sv @@
module testbench;
  import iqpd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_beat_t out_data;
  logic cfg_we = 0;
  logic [15:0] cfg_data = '0;
  int fail_count;
  int reports_waiting;
  int cycle_cnt = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  logic signed [15:0] walk_q [4];

  localparam int CYCLE_LIMIT = 10_000_000;

  imu_quaternion_to_pointer_delta u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  pointer_delta_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .reports_waiting(reports_waiting)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 300);
  endfunction

  // receiver stall: random gaps, plus a long hold-off on demand
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (4000) @(posedge clk);
        hold_off = 0;
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_beat(in_beat_t b, bit idle_ok);
    int n;
    n = idle_ok ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic in_beat_t sample_beat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z);
    in_beat_t b;
    b = '0;
    b.op = 1'b0;
    b.quat_w = w; b.quat_x = x; b.quat_y = y; b.quat_z = z;
    b.base_x = 8'($urandom); b.base_y = 8'($urandom);
    return b;
  endfunction

  function automatic in_beat_t report_beat(logic [7:0] bx, logic [7:0] by);
    in_beat_t b;
    b = '0;
    b.op = 1'b1;
    b.quat_w = 16'($urandom); b.quat_x = 16'($urandom);
    b.quat_y = 16'($urandom); b.quat_z = 16'($urandom);
    b.base_x = bx; b.base_y = by;
    return b;
  endfunction

  function automatic logic [7:0] rand_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'sd127;
    if (r == 2) return -8'sd127;
    if (r == 3) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_gain(logic [15:0] g);
    cfg_we <= 1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // small random rotation steps around a unit-ish quaternion
  task automatic walk_step();
    for (int i = 0; i < 4; i++)
      walk_q[i] = walk_q[i] + 16'(int'($urandom_range(0, 800)) - 400);
    send_beat(sample_beat(walk_q[0], walk_q[1], walk_q[2], walk_q[3]), 1);
  endtask

  task automatic random_phase(int count);
    int r;
    walk_q[0] = 16'sd16384; walk_q[1] = 0; walk_q[2] = 0; walk_q[3] = 0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) walk_step();
      else if (r < 85) send_beat(report_beat(rand_base(), rand_base()), 1);
      else send_beat(sample_beat(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom)), 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // first sample, extremes, saturation, bases at the rails
    send_beat(sample_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 0);
    send_beat(report_beat(8'h80, 8'h80), 0);
    send_beat(sample_beat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF), 0);
    send_beat(sample_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 0);
    send_beat(sample_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000), 0);
    send_beat(report_beat(8'sd127, -8'sd127), 0);
    send_beat(report_beat(8'h80, 8'sd0), 0);
    send_beat(report_beat(8'sd0, 8'h80), 0);
    send_beat(report_beat(-8'sd127, 8'sd127), 0);
    send_beat(sample_beat(16'sd16384, 16'sd0, 16'sd0, 16'sd0), 0);
    send_beat(sample_beat(16'sd16000, 16'sd2000, 16'sd0, 16'sd3000), 0);
    send_beat(sample_beat(16'sd16000, 16'sd2000, 16'sd0, 16'sd3000), 0);
    send_beat(report_beat(8'sd0, 8'sd0), 0);
    send_beat(report_beat(8'sd0, 8'sd0), 0);
    send_beat(report_beat(8'h80, 8'h80), 0);
    wait_idle();

    set_gain(16'd0);
    random_phase(300);
    wait_idle();
    set_gain(16'hFFFF);
    random_phase(300);
    wait_idle();
    set_gain(16'd1);
    random_phase(300);
    wait_idle();
    set_gain(16'($urandom));
    // long receiver hold-off while items keep coming
    hold_off = 1;
    random_phase(200);
    wait_idle();
    set_gain(ANG_SCALE_RST);
    random_phase(800);
    wait_idle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/iqpd_pkg.sv
rtl/iqpd_serial_mul.sv
rtl/imu_quaternion_to_pointer_delta.sv
rtl/iqpd_checker.sv
test/pointer_delta_checker.sv
test/testbench.sv
